@@ rtl/core/lsr_pkg.sv @@
// Shared constants, status codes and fixed-point helpers for the speed regulator.
package lsr_pkg;

  // Fixed-point format of every operand and result.
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  // APB register map: four 32-bit registers at byte addresses 0, 4, 8 and 12.
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_COEF_B = 2'd0;
  localparam logic [1:0] REG_COEF_C = 2'd1;
  localparam logic [1:0] REG_COEF_D = 2'd2;
  localparam logic [1:0] REG_COEF_E = 2'd3;

  // Coefficient reset value, 1.0.
  localparam logic signed [31:0] COEF_ONE = 32'sd1 <<< FRAC_BITS;

  // Stop-time offset, 1.2 rounded to nearest.
  localparam logic signed [31:0] ONE_P_TWO = 32'((12 * (1 << FRAC_BITS) + 5) / 10);

  // Exact unsigned 32-bit divide by six: multiply by this and shift right.
  localparam logic [31:0] DIV6_MAGIC = 32'hAAAA_AAAB;
  localparam int          DIV6_SHIFT = 34;

  // Divider pipeline: one set-up stage, iterating stages, one sign/clamp stage.
  localparam int DIV_Q_BITS  = 32;
  localparam int DIV_PER_STG = 4;
  localparam int DIV_ITER    = DIV_Q_BITS / DIV_PER_STG;
  localparam int DIV_LAT     = DIV_ITER + 2;

  // Datapath stages before the dividers, and the total stage count.
  localparam int PRE_DIV = 12;
  localparam int NSTAGE  = PRE_DIV + DIV_LAT + 3;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Sign extension of a 32-bit value to 64 bits.
  function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  // Full signed 32 by 32 product.
  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sx64(a) * sx64(b);
  endfunction

  // Fixed-point rescale of a product, rounding towards minus infinity.
  function automatic logic signed [63:0] fxm(input logic signed [63:0] p);
    return p >>> FRAC_BITS;
  endfunction

  // True when a value lies outside the signed 32-bit range.
  function automatic logic ovf32(input logic signed [63:0] x);
    return (x > S32_MAX) || (x < S32_MIN);
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/lsr_div.sv @@
// Pipelined signed fixed-point divider, four quotient bits per stage, clamped result.
module lsr_div import lsr_pkg::*; (
  input  logic                    clk,
  input  logic [DIV_LAT-1:0]      en,
  input  logic signed [32:0]      num,
  input  logic signed [31:0]      den,
  output logic signed [31:0]      quo,
  output logic                    ovf
);

  typedef struct packed {
    logic        neg;
    logic        pre_ovf;
    logic [31:0] dv;
    logic [32:0] rem;
    logic [31:0] lo;
  } dstage_t;

  dstage_t stg [0:DIV_ITER];
  dstage_t stg_next [0:DIV_ITER];
  logic signed [31:0] quo_next;
  logic               ovf_next;

  // Set-up: magnitudes, scaled numerator and early overflow detection.
  // Then the restoring division steps; the low word fills with quotient bits.
  always_comb begin
    logic [32:0]             an;
    logic [31:0]             ad;
    logic [33+FRAC_BITS-1:0] nfull;
    logic [33+FRAC_BITS-1:0] hi;
    logic [32:0]             r;
    logic [31:0]             l;
    an    = num[32] ? (~num + 33'd1) : num;
    ad    = den[31] ? (~den + 32'd1) : den;
    nfull = {an, {FRAC_BITS{1'b0}}};
    hi    = nfull >> DIV_Q_BITS;
    stg_next[0].neg     = num[32] ^ den[31];
    stg_next[0].pre_ovf = hi >= {{(1+FRAC_BITS){1'b0}}, ad};
    stg_next[0].dv      = ad;
    stg_next[0].rem     = hi[32:0];
    stg_next[0].lo      = nfull[31:0];

    for (int j = 1; j <= DIV_ITER; j++) begin
      stg_next[j] = stg[j-1];
      r = stg[j-1].rem;
      l = stg[j-1].lo;
      for (int s = 0; s < DIV_PER_STG; s++) begin
        r = {r[31:0], l[31]};
        l = {l[30:0], 1'b0};
        if (r >= {1'b0, stg[j-1].dv}) begin
          r    = r - {1'b0, stg[j-1].dv};
          l[0] = 1'b1;
        end
      end
      stg_next[j].rem = r;
      stg_next[j].lo  = l;
    end
  end

  // Apply the sign and clamp to the signed 32-bit range.
  always_comb begin
    logic [31:0] qm;
    qm = stg[DIV_ITER].lo;
    if (stg[DIV_ITER].pre_ovf) begin
      ovf_next = 1'b1;
      quo_next = stg[DIV_ITER].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (stg[DIV_ITER].neg) begin
      ovf_next = qm > 32'h8000_0000;
      quo_next = ovf_next ? 32'sh8000_0000 : $signed(~qm + 32'd1);
    end else begin
      ovf_next = qm[31];
      quo_next = ovf_next ? 32'sh7FFF_FFFF : $signed(qm);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j <= DIV_ITER; j++) begin
      if (en[j]) begin
        stg[j] <= stg_next[j];
      end
    end
    if (en[DIV_LAT-1]) begin
      quo <= quo_next;
      ovf <= ovf_next;
    end
  end

endmodule

@@ rtl/core/lsr_datapath.sv @@
// Torque datapath: multiplier stages, four dividers and the final sum, with valid bits.
module lsr_datapath import lsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] coef_b,
  input  logic signed [31:0] coef_c,
  input  logic signed [31:0] coef_d,
  input  logic signed [31:0] coef_e,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] speed_target,
  input  logic signed [31:0] tilt,
  input  logic signed [31:0] tilt_rate,
  input  logic signed [31:0] speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] torque,
  output logic [1:0]         status
);

  typedef struct packed {
    logic signed [31:0] sp;
    logic signed [31:0] th;
    logic signed [31:0] thd;
    logic signed [31:0] v;
    logic signed [31:0] t;
    logic signed [31:0] t2;
    logic signed [31:0] te;
    logic signed [31:0] t3;
    logic signed [31:0] a;
    logic signed [31:0] h;
    logic signed [31:0] he;
    logic signed [31:0] ke;
    logic signed [31:0] b;
    logic signed [31:0] tb;
    logic signed [31:0] ked;
    logic signed [31:0] den3;
    logic signed [31:0] n1;
    logic signed [31:0] nthd;
    logic signed [31:0] two_d;
    logic signed [31:0] n3;
    logic signed [31:0] q1;
    logic signed [31:0] q2;
    logic signed [31:0] q3;
    logic signed [31:0] t4;
    logic signed [31:0] tau;
    logic [31:0]        k;
    logic signed [32:0] ncd;
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    logic signed [63:0] pc;
    logic [63:0]        pk;
    logic               dzero;
    logic               zero;
    logic               sat;
    logic [1:0]         st;
  } ctx_t;

  ctx_t pipe [0:NSTAGE-1];
  ctx_t pipe_next [0:NSTAGE-1];
  logic vld [0:NSTAGE-1];
  logic en  [0:NSTAGE];

  logic signed [31:0] q1, q2, q3, qcd;
  logic               o1, o2, o3, ocd;
  logic [DIV_LAT-1:0] div_en;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[NSTAGE] = !out_stall;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    for (int j = 0; j < DIV_LAT; j++) begin
      div_en[j] = en[PRE_DIV + j];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSTAGE-1];
  assign torque    = pipe[NSTAGE-1].tau;
  assign status    = pipe[NSTAGE-1].st;

  // Stage logic; every stage passes on what it does not change.
  always_comb begin
    logic [32:0]        d33;
    logic [32:0]        ad;
    logic signed [63:0] w;
    logic signed [63:0] w2;
    logic signed [63:0] sum;
    pipe_next[0] = pipe[0];
    for (int k = 1; k < NSTAGE; k++) begin
      pipe_next[k] = pipe[k-1];
    end

    // Capture the sample.
    pipe_next[0].sp  = speed_target;
    pipe_next[0].th  = tilt;
    pipe_next[0].thd = tilt_rate;
    pipe_next[0].v   = speed;
    pipe_next[0].sat = 1'b0;

    // Stop time, numerators of the tilt terms and the doubled divisor.
    d33 = {pipe[0].sp[31], pipe[0].sp} - {pipe[0].v[31], pipe[0].v};
    ad  = d33[32] ? (~d33 + 33'd1) : d33;
    w   = $signed({32'b0, ad[32:1]}) + sx64(ONE_P_TWO);
    pipe_next[1].t = sat32(w);
    w2  = -sx64(pipe[0].th) - (sx64(pipe[0].thd) <<< 1);
    pipe_next[1].n1 = sat32(w2);
    pipe_next[1].nthd  = sat32(-sx64(pipe[0].thd));
    pipe_next[1].two_d = sat32(sx64(coef_d) <<< 1);
    pipe_next[1].ncd   = ~{coef_c[31], coef_c} + 33'd1;
    pipe_next[1].dzero = (coef_d == 32'sd0);
    pipe_next[1].sat   = pipe[0].sat | ovf32(w) | ovf32(w2) |
                         ovf32(-sx64(pipe[0].thd)) | ovf32(sx64(coef_d) <<< 1);

    // t squared and t times E.
    pipe_next[2].pa = mul32(pipe[1].t, pipe[1].t);
    pipe_next[2].pb = mul32(pipe[1].t, coef_e);

    pipe_next[3].t2  = sat32(fxm(pipe[2].pa));
    pipe_next[3].te  = sat32(fxm(pipe[2].pb));
    pipe_next[3].sat = pipe[2].sat | ovf32(fxm(pipe[2].pa)) | ovf32(fxm(pipe[2].pb));

    // t cubed and the tilt correction.
    pipe_next[4].pa = mul32(pipe[3].t2, pipe[3].t);
    pipe_next[4].pb = mul32(pipe[3].te, pipe[3].th);

    pipe_next[5].t3  = sat32(fxm(pipe[4].pa));
    pipe_next[5].a   = sat32(fxm(pipe[4].pb));
    pipe_next[5].h   = pipe[4].t2 >>> 1;
    pipe_next[5].sat = pipe[4].sat | ovf32(fxm(pipe[4].pa)) | ovf32(fxm(pipe[4].pb));

    // Divide t cubed by six; half t squared times E.
    pipe_next[6].pk = {32'b0, pipe[5].t3} * {32'b0, DIV6_MAGIC};
    pipe_next[6].pb = mul32(pipe[5].h, coef_e);

    pipe_next[7].k   = 32'(pipe[6].pk >> DIV6_SHIFT);
    pipe_next[7].he  = sat32(fxm(pipe[6].pb));
    pipe_next[7].sat = pipe[6].sat | ovf32(fxm(pipe[6].pb));

    // Cubic term times E, rate correction, linear part of the denominator.
    pipe_next[8].pa = mul32($signed(pipe[7].k), coef_e);
    pipe_next[8].pb = mul32(pipe[7].he, pipe[7].thd);
    pipe_next[8].pc = mul32(pipe[7].t, coef_b);

    pipe_next[9].ke  = sat32(fxm(pipe[8].pa));
    pipe_next[9].b   = sat32(fxm(pipe[8].pb));
    pipe_next[9].tb  = sat32(fxm(pipe[8].pc));
    pipe_next[9].sat = pipe[8].sat | ovf32(fxm(pipe[8].pa)) | ovf32(fxm(pipe[8].pb)) |
                       ovf32(fxm(pipe[8].pc));

    pipe_next[10].pa = mul32(pipe[9].ke, coef_d);

    // Denominator and numerator of the velocity term, and the zero-divisor test.
    pipe_next[11].ked = sat32(fxm(pipe[10].pa));
    w   = sx64(pipe[10].tb) + sx64(sat32(fxm(pipe[10].pa)));
    w2  = sx64(pipe[10].sp) - sx64(pipe[10].v) - sx64(pipe[10].a) - sx64(pipe[10].b);
    pipe_next[11].den3 = sat32(w);
    pipe_next[11].n3   = sat32(w2);
    pipe_next[11].zero = pipe[10].dzero | (sat32(w) == 32'sd0);
    pipe_next[11].sat  = pipe[10].sat | ovf32(fxm(pipe[10].pa)) | ovf32(w) | ovf32(w2);

    // Quotients arrive; coefficient ratio times tilt.
    pipe_next[PRE_DIV+DIV_LAT].q1  = q1;
    pipe_next[PRE_DIV+DIV_LAT].q2  = q2;
    pipe_next[PRE_DIV+DIV_LAT].q3  = q3;
    pipe_next[PRE_DIV+DIV_LAT].pa  = mul32(qcd, pipe[PRE_DIV+DIV_LAT-1].th);
    pipe_next[PRE_DIV+DIV_LAT].sat = pipe[PRE_DIV+DIV_LAT-1].sat | o1 | o2 | o3 | ocd;

    pipe_next[PRE_DIV+DIV_LAT+1].t4  = sat32(fxm(pipe[PRE_DIV+DIV_LAT].pa));
    pipe_next[PRE_DIV+DIV_LAT+1].sat = pipe[PRE_DIV+DIV_LAT].sat |
                                       ovf32(fxm(pipe[PRE_DIV+DIV_LAT].pa));

    // Sum of the four terms, clamp and status.
    sum = sx64(pipe[NSTAGE-2].q1) + sx64(pipe[NSTAGE-2].q2) +
          sx64(pipe[NSTAGE-2].q3) + sx64(pipe[NSTAGE-2].t4);
    if (pipe[NSTAGE-2].zero) begin
      pipe_next[NSTAGE-1].tau = 32'sd0;
      pipe_next[NSTAGE-1].st  = ST_DIVZ;
    end else begin
      pipe_next[NSTAGE-1].tau = sat32(sum);
      pipe_next[NSTAGE-1].st  = (pipe[NSTAGE-2].sat | ovf32(sum)) ? ST_SAT : ST_OK;
    end
  end

  // Four dividers in parallel, aligned with the middle stages.
  lsr_div u_div_t1 (
    .clk(clk), .en(div_en),
    .num({pipe[PRE_DIV-1].n1[31], pipe[PRE_DIV-1].n1}),
    .den(pipe[PRE_DIV-1].two_d), .quo(q1), .ovf(o1)
  );

  lsr_div u_div_t2 (
    .clk(clk), .en(div_en),
    .num({pipe[PRE_DIV-1].nthd[31], pipe[PRE_DIV-1].nthd}),
    .den(pipe[PRE_DIV-1].two_d), .quo(q2), .ovf(o2)
  );

  lsr_div u_div_t3 (
    .clk(clk), .en(div_en),
    .num({pipe[PRE_DIV-1].n3[31], pipe[PRE_DIV-1].n3}),
    .den(pipe[PRE_DIV-1].den3), .quo(q3), .ovf(o3)
  );

  lsr_div u_div_cd (
    .clk(clk), .en(div_en),
    .num(pipe[PRE_DIV-1].ncd),
    .den(coef_d), .quo(qcd), .ovf(ocd)
  );

  // Payload registers and valid bits.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTAGE; k++) begin
      if (en[k]) begin
        pipe[k] <= pipe_next[k];
      end
    end
    if (rst) begin
      for (int k = 0; k < NSTAGE; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

endmodule

@@ rtl/core/lookahead_speed_regulator_unit.sv @@
// Top level of the look-ahead speed regulator: APB coefficient registers and datapath.
// Throughput: one sample per cycle while the output is not stalled; the 32-bit dividers,
// at four quotient bits per stage, and the chain of registered multipliers make up the
// 25 pipeline stages. A stalled output holds its result; empty stages keep filling behind it.
// Reset clears all valid bits and sets the four coefficients to 1.0.
module lookahead_speed_regulator_unit import lsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] speed_target,
  input  logic signed [31:0] tilt,
  input  logic signed [31:0] tilt_rate,
  input  logic signed [31:0] speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] torque,
  output logic [1:0]         status
);

  logic signed [31:0] coef_b, coef_c, coef_d, coef_e;
  logic [1:0]         reg_idx;
  logic               wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;

  // Coefficient register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b <= COEF_ONE;
      coef_c <= COEF_ONE;
      coef_d <= COEF_ONE;
      coef_e <= COEF_ONE;
    end else if (wr) begin
      case (reg_idx)
        REG_COEF_B: coef_b <= $signed(pwdata);
        REG_COEF_C: coef_c <= $signed(pwdata);
        REG_COEF_D: coef_d <= $signed(pwdata);
        REG_COEF_E: coef_e <= $signed(pwdata);
        default:    coef_b <= coef_b;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_COEF_B: prdata = coef_b;
      REG_COEF_C: prdata = coef_c;
      REG_COEF_D: prdata = coef_d;
      REG_COEF_E: prdata = coef_e;
      default:    prdata = 32'd0;
    endcase
  end

  lsr_datapath u_datapath (
    .clk(clk), .rst(rst),
    .coef_b(coef_b), .coef_c(coef_c), .coef_d(coef_d), .coef_e(coef_e),
    .in_valid(in_valid), .in_stall(in_stall),
    .speed_target(speed_target), .tilt(tilt), .tilt_rate(tilt_rate), .speed(speed),
    .out_valid(out_valid), .out_stall(out_stall),
    .torque(torque), .status(status)
  );

endmodule

@@ rtl/core/lsr_checker.sv @@
// Port-level checks on the speed regulator, bound to the top level.
module lsr_checker import lsr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] torque,
  input logic [1:0]         status
);

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // A zero-divisor result always carries a zero torque.
  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DIVZ) |-> (torque == 32'sd0))
    else $error("zero-divisor result with non-zero torque");

  // Status is one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_DIVZ))
    else $error("undefined status code");

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(torque) && $stable(status)))
    else $error("stalled result changed");

  // With an empty output stage the input side is never stalled.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty pipeline end");

endmodule

bind lookahead_speed_regulator_unit lsr_checker u_lsr_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .torque(torque), .status(status)
);

@@ dv/lookahead_speed_regulator_unit_tb.sv @@
// Self-checking testbench for the look-ahead speed regulator, with a built-in torque predictor.
module lookahead_speed_regulator_unit_tb;
  import lsr_pkg::*;

  typedef struct packed {
    logic signed [31:0] speed_target;
    logic signed [31:0] tilt;
    logic signed [31:0] tilt_rate;
    logic signed [31:0] speed;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] torque;
    logic [1:0]         status;
  } torque_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_LEN    = 400;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] speed_target;
  logic signed [31:0] tilt;
  logic signed [31:0] tilt_rate;
  logic signed [31:0] speed;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] torque;
  logic [1:0]         status;

  // Predictor copy of the coefficient registers.
  logic signed [31:0] mdl_b, mdl_c, mdl_d, mdl_e;

  sample_t sample_q[$];
  torque_t torque_q[$];
  int      send_idle;
  int      recv_idle;
  int      mismatches;
  int      cycles;
  logic    sample_taken;
  logic    hold_go;
  logic    hold_done;
  int      hold_cnt;

  lookahead_speed_regulator_unit dut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Clamp to the signed 32-bit range, noting saturation.
  function automatic longint clip(input longint x, inout bit sat);
    if (x > S32_MAX) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (x < S32_MIN) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return x;
  endfunction

  function automatic longint fmul(input longint a, input longint b, inout bit sat);
    return clip((a * b) >>> FRAC_BITS, sat);
  endfunction

  function automatic longint fdiv(input longint n, input longint d, inout bit sat);
    return clip((n * (64'sd1 <<< FRAC_BITS)) / d, sat);
  endfunction

  // Expected torque and status for one sensor sample.
  function automatic torque_t predict_torque(input sample_t s);
    longint sp, th, thd, v, diff, t, t2, t3, k, den, two_d, n1, tm1, tm2;
    longint a, h, b, n3, tm3, cd, tm4, tau;
    bit sat;
    torque_t r;
    sat = 1'b0;
    sp = s.speed_target;
    th = s.tilt;
    thd = s.tilt_rate;
    v = s.speed;
    diff = sp - v;
    if (diff < 0) diff = -diff;
    t = clip((diff >>> 1) + longint'(ONE_P_TWO), sat);
    t2 = fmul(t, t, sat);
    t3 = fmul(t2, t, sat);
    k = t3 / 6;
    den = clip(fmul(t, mdl_b, sat) + fmul(fmul(k, mdl_e, sat), mdl_d, sat), sat);
    if (mdl_d == 0 || den == 0) begin
      r.torque = '0;
      r.status = ST_DIVZ;
      return r;
    end
    two_d = clip(2 * longint'(mdl_d), sat);
    n1 = clip(-th - 2 * thd, sat);
    tm1 = fdiv(n1, two_d, sat);
    tm2 = fdiv(clip(-thd, sat), two_d, sat);
    a = fmul(fmul(t, mdl_e, sat), th, sat);
    h = t2 >>> 1;
    b = fmul(fmul(h, mdl_e, sat), thd, sat);
    n3 = clip(sp - v - a - b, sat);
    tm3 = fdiv(n3, den, sat);
    cd = fdiv(-longint'(mdl_c), mdl_d, sat);
    tm4 = fmul(cd, th, sat);
    tau = clip(tm1 + tm2 + tm3 + tm4, sat);
    r.torque = tau[31:0];
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Field value: mostly a few units either side of zero, sometimes full range, an extreme or zero.
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    if (sel < 85) return $urandom;
    if (sel < 90) return 32'sh7FFF_FFFF;
    if (sel < 95) return 32'sh8000_0000;
    return '0;
  endfunction

  function automatic logic signed [31:0] pick_coef();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $signed($urandom_range(1, 1 << 19)) - (1 << 18);
    if (sel < 9) return $urandom;
    return '0;
  endfunction

  // Clock cycle counter and run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lookahead_speed_regulator_unit regression: fail");
      $finish;
    end
  end

  // Long receiver hold-off, counted here once requested.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
    end
  end

  // Input transfers: predict the result of each accepted sample.
  always @(posedge clk) begin
    sample_taken <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) begin
      torque_q.push_back(predict_torque({speed_target, tilt, tilt_rate, speed}));
    end
  end

  // Sample driver, fed from the pending queue.
  always @(negedge clk) begin
    sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sample_taken) begin
      if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        s = sample_q.pop_front();
        speed_target <= s.speed_target;
        tilt <= s.tilt;
        tilt_rate <= s.tilt_rate;
        speed <= s.speed;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, random or held off for a long stretch.
  always @(negedge clk) begin
    out_stall <= (hold_go && !hold_done) || ($urandom_range(0, 99) < recv_idle);
  end

  // Result monitor: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    torque_t e;
    if (!rst && out_valid && !out_stall) begin
      if (torque_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result torque=%h status=%0d", torque, status);
      end else begin
        e = torque_q.pop_front();
        if (e.torque !== torque || e.status !== status) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("mismatch: expected torque=%h status=%0d, got torque=%h status=%0d",
                     e.torque, e.status, torque, status);
          end
        end
      end
    end
  end

  // One APB write; the predictor copy follows it.
  task automatic reg_write(input logic [1:0] idx, input logic signed [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COEF_B: mdl_b = val;
      REG_COEF_C: mdl_c = val;
      REG_COEF_D: mdl_d = val;
      default:    mdl_e = val;
    endcase
  endtask

  task automatic set_coefs(input logic signed [31:0] b, input logic signed [31:0] c,
                           input logic signed [31:0] d, input logic signed [31:0] e);
    reg_write(REG_COEF_B, b);
    reg_write(REG_COEF_C, c);
    reg_write(REG_COEF_D, d);
    reg_write(REG_COEF_E, e);
  endtask

  task automatic push_sample(input logic signed [31:0] sp, input logic signed [31:0] th,
                             input logic signed [31:0] thd, input logic signed [31:0] v);
    sample_t s;
    s = '{sp, th, thd, v};
    sample_q.push_back(s);
  endtask

  task automatic push_random(input int n);
    repeat (n) push_sample(pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  // Wait until every sample is sent and every result has come, then let the pipe empty.
  task automatic drain();
    while (sample_q.size() > 0 || in_valid || torque_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    speed_target = '0;
    tilt = '0;
    tilt_rate = '0;
    speed = '0;
    mismatches = 0;
    cycles = 0;
    hold_go = 1'b0;
    sample_taken = 1'b0;
    mdl_b = COEF_ONE;
    mdl_c = COEF_ONE;
    mdl_d = COEF_ONE;
    mdl_e = COEF_ONE;
    send_idle = 20;
    recv_idle = 84;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed samples at reset coefficients: zeros, extremes and saturating stop times.
    push_sample(0, 0, 0, 0);
    push_sample(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000);
    push_sample(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF);
    push_sample(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    push_sample(0, 32'sh8000_0000, 32'sh8000_0000, 0);
    push_sample(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    push_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_sample(32'sh0001_0000, 32'sh0000_1000, -32'sh0000_2000, 32'sh0000_8000);
    push_sample(-32'sh0002_0000, -32'sh0000_0100, 32'sh0000_0080, 32'sh0003_0000);
    push_sample(-1, -1, -1, -1);
    push_sample(1, 1, 1, 1);
    push_random(300);
    drain();

    // Zero denominator of the velocity term: B and E both zero.
    set_coefs(0, COEF_ONE, COEF_ONE, 0);
    push_sample(0, 0, 0, 0);
    push_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000);
    push_random(120);
    drain();

    // Zero D coefficient.
    set_coefs(COEF_ONE, COEF_ONE, 0, COEF_ONE);
    push_sample(0, 0, 0, 0);
    push_random(100);
    drain();

    // Idling the other way round, with a long receiver hold-off filling the pipe.
    send_idle = 84;
    recv_idle = 20;
    set_coefs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_random(200);
    drain();
    set_coefs(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_idle = 0;
    hold_go = 1'b1;
    push_random(200);
    drain();
    send_idle = 84;
    set_coefs(32'sh0000_8000, -32'sh0003_0000, 32'sh0000_0001, 32'sh0002_0000);
    push_random(200);
    drain();

    // No idling on either side, random coefficient sets.
    send_idle = 0;
    recv_idle = 0;
    repeat (6) begin
      set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
      push_random(130);
      drain();
    end
    set_coefs(COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE);
    push_random(100);
    drain();

    if (mismatches == 0) begin
      $display("lookahead_speed_regulator_unit regression: pass");
    end else begin
      $display("lookahead_speed_regulator_unit regression: fail");
    end
    $finish;
  end

endmodule
